[rtl/umlp_pkg.sv]
// Shared types, widths and constants for the ultrasonic median level block.
// No dependencies; imported by every module under rtl/.
package umlp_pkg;

  localparam int SAMPLE_COUNT = 5;
  localparam int ECHO_W       = 14;
  localparam int DIST_W       = 9;    // floor(16383*17/1000) = 278
  localparam int RANK_W       = $clog2(SAMPLE_COUNT);
  localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int PCT_W        = 7;
  localparam int NUM_W        = 15;   // (empty - median) * 100 <= 25500

  // floor(w*17/1000) == (w * ceil(2^29/1000) * 17) >> 29, exact for w < 2^14
  localparam int                 SCALE_SHIFT = 29;
  localparam int                 PROD_W      = ECHO_W + 24;
  localparam logic [23:0]        SCALE_MUL   = 24'd9126807;

  localparam logic [CFG_W-1:0]   FULL_RESET  = 8'd25;
  localparam logic [CFG_W-1:0]   EMPTY_RESET = 8'd130;
  localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
  localparam logic [PCT_W-1:0]   BAND_LOW_MAX = 7'd30;
  localparam logic [PCT_W-1:0]   BAND_MID_MAX = 7'd70;

  localparam logic [CFG_IDX_W-1:0] REG_FULL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 1'b1;

  // lanes (2) + merge (2) + divider (one stage per quotient bit) + output (1)
  localparam int LATENCY = 4 + PCT_W + 1;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef logic [DIST_W-1:0]                     dist_t;
  typedef logic [SAMPLE_COUNT-1:0][DIST_W-1:0]   dist_vec_t;
  typedef logic [SAMPLE_COUNT-1:0][RANK_W-1:0]   rank_vec_t;
  typedef logic [SAMPLE_COUNT-1:0][ECHO_W-1:0]   echo_vec_t;

  typedef struct packed {
    logic             err;
    logic [CFG_W-1:0] median;
    logic [CNT_W-1:0] count;
  } meta_t;

endpackage

[rtl/umlp_lane.sv]
// One sample lane: echo width to distance, then rank among the valid distances.
// Depends on umlp_pkg.
module umlp_lane #(
  parameter int LANE = 0
) (
  input  logic                           clk,
  input  logic [umlp_pkg::ECHO_W-1:0]    echo,
  output umlp_pkg::dist_t                dist_cm,
  output logic                           hit,
  input  umlp_pkg::dist_vec_t            dist_all,
  input  logic [umlp_pkg::SAMPLE_COUNT-1:0] hit_all,
  output logic [umlp_pkg::RANK_W-1:0]    rank,
  output umlp_pkg::dist_t                dist_q,
  output logic                           hit_q
);
  import umlp_pkg::*;

  logic [PROD_W-1:0] prod;
  dist_t             dist_cm_next;
  logic [RANK_W-1:0] rank_next;

  assign prod         = PROD_W'(echo) * PROD_W'(SCALE_MUL);
  assign dist_cm_next = prod[SCALE_SHIFT +: DIST_W];

  // ties broken by lane order so every valid lane gets a distinct rank
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < SAMPLE_COUNT; j++) begin
      if (j != LANE && hit_all[j] &&
          (dist_all[j] < dist_cm || (dist_all[j] == dist_cm && j < LANE))) begin
        rank_next = rank_next + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_cm <= dist_cm_next;
    hit     <= (dist_cm_next != '0);
    rank    <= rank_next;
    dist_q  <= dist_cm;
    hit_q   <= hit;
  end

endmodule

[rtl/umlp_merge.sv]
// Merge stage: picks the median lane, clamps it and forms the level fraction.
// Depends on umlp_pkg.
module umlp_merge (
  input  logic                              clk,
  input  umlp_pkg::dist_vec_t               dist_cm,
  input  logic [umlp_pkg::SAMPLE_COUNT-1:0] hit,
  input  umlp_pkg::rank_vec_t               rank,
  input  logic [umlp_pkg::CFG_W-1:0]        full_distance_cm,
  input  logic [umlp_pkg::CFG_W-1:0]        empty_distance_cm,
  output logic [umlp_pkg::NUM_W-1:0]        num,
  output logic [umlp_pkg::CFG_W-1:0]        den,
  output umlp_pkg::meta_t                   meta
);
  import umlp_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [RANK_W-1:0] mid;
  dist_t             med;
  logic [CFG_W-1:0]  med_clamp;
  meta_t             meta_a;
  meta_t             meta_a_next;
  logic [CFG_W-1:0]  diff;

  assign count = CNT_W'($countones(hit));
  assign mid   = RANK_W'(count >> 1);

  always_comb begin
    med = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (hit[i] && rank[i] == mid) begin
        med = med | dist_cm[i];
      end
    end
  end

  always_comb begin
    if (med < DIST_W'(full_distance_cm)) begin
      med_clamp = full_distance_cm;
    end else if (med > DIST_W'(empty_distance_cm)) begin
      med_clamp = empty_distance_cm;
    end else begin
      med_clamp = med[CFG_W-1:0];
    end
  end

  always_comb begin
    meta_a_next.count  = count;
    meta_a_next.err    = (count == '0) || (empty_distance_cm <= full_distance_cm);
    meta_a_next.median = (count == '0) ? '0 : med_clamp;
  end

  assign diff = empty_distance_cm - meta_a.median;

  always_ff @(posedge clk) begin
    meta_a <= meta_a_next;
    meta   <= meta_a;
    if (meta_a.err) begin
      num <= '0;
      den <= CFG_W'(1);
    end else begin
      num <= NUM_W'(diff) * NUM_W'(PCT_SCALE);
      den <= empty_distance_cm - full_distance_cm;
    end
  end

endmodule

[rtl/umlp_div.sv]
// Pipelined restoring divider, one quotient bit per stage; quotient fits PCT_W.
// Depends on umlp_pkg.
module umlp_div (
  input  logic                          clk,
  input  logic [umlp_pkg::NUM_W-1:0]    num,
  input  logic [umlp_pkg::CFG_W-1:0]    den,
  input  umlp_pkg::meta_t               meta_in,
  output logic [umlp_pkg::PCT_W-1:0]    quo,
  output umlp_pkg::meta_t               meta_out
);
  import umlp_pkg::*;

  logic [NUM_W-1:0] rem_s  [PCT_W+1];
  logic [CFG_W-1:0] den_s  [PCT_W+1];
  logic [PCT_W-1:0] quo_s  [PCT_W+1];
  meta_t            meta_s [PCT_W+1];

  assign rem_s[0]  = num;
  assign den_s[0]  = den;
  assign quo_s[0]  = '0;
  assign meta_s[0] = meta_in;

  for (genvar s = 0; s < PCT_W; s++) begin : g_stage
    localparam int BIT = PCT_W - 1 - s;
    logic [NUM_W-1:0] trial;
    logic             take;

    assign trial = NUM_W'(den_s[s]) << BIT;
    assign take  = (rem_s[s] >= trial);

    always_ff @(posedge clk) begin
      rem_s[s+1]  <= take ? rem_s[s] - trial : rem_s[s];
      den_s[s+1]  <= den_s[s];
      quo_s[s+1]  <= quo_s[s] | (PCT_W'(take) << BIT);
      meta_s[s+1] <= meta_s[s];
    end
  end

  assign quo      = quo_s[PCT_W];
  assign meta_out = meta_s[PCT_W];

endmodule

[rtl/ultrasonic_median_level_percent.sv]
// Pipeline: a request passes through the lane, merge, divider and output registers in order.
// Throughput: one request per cycle, set by the fully pipelined divider (one stage
// per quotient bit); busy is high only while rst is held.
// Reset: synchronous, clears the in-flight valid pipeline and loads the
// full/empty distance registers with 25 cm and 130 cm. The receiver cannot stall.
module ultrasonic_median_level_percent (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_we,
  input  logic [umlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [umlp_pkg::CFG_W-1:0]       cfg_data,
  input  logic [umlp_pkg::ECHO_W-1:0]      echo_us_0,
  input  logic [umlp_pkg::ECHO_W-1:0]      echo_us_1,
  input  logic [umlp_pkg::ECHO_W-1:0]      echo_us_2,
  input  logic [umlp_pkg::ECHO_W-1:0]      echo_us_3,
  input  logic [umlp_pkg::ECHO_W-1:0]      echo_us_4,
  output logic                             done,
  output logic [umlp_pkg::PCT_W-1:0]       level_percent,
  output logic [umlp_pkg::CFG_W-1:0]       median_cm,
  output logic [1:0]                       level_band,
  output logic                             sensor_error,
  output logic [umlp_pkg::CNT_W-1:0]       valid_count
);
  import umlp_pkg::*;

  logic [CFG_W-1:0]        full_distance_cm;
  logic [CFG_W-1:0]        empty_distance_cm;
  logic [LATENCY-1:0]      vld;
  echo_vec_t               echo;
  dist_vec_t               dist_cm;
  logic [SAMPLE_COUNT-1:0] hit;
  rank_vec_t               rank;
  dist_vec_t               dist_q;
  logic [SAMPLE_COUNT-1:0] hit_q;
  logic [NUM_W-1:0]        num;
  logic [CFG_W-1:0]        den;
  meta_t                   meta_m;
  meta_t                   meta_d;
  logic [PCT_W-1:0]        quo;
  band_t                   band_next;

  assign busy = rst;

  assign echo[0] = echo_us_0;
  assign echo[1] = echo_us_1;
  assign echo[2] = echo_us_2;
  assign echo[3] = echo_us_3;
  assign echo[4] = echo_us_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_distance_cm  <= FULL_RESET;
      empty_distance_cm <= EMPTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL:  full_distance_cm  <= cfg_data;
        REG_EMPTY: empty_distance_cm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_lane
    umlp_lane #(.LANE(i)) u_lane (
      .clk      (clk),
      .echo     (echo[i]),
      .dist_cm  (dist_cm[i]),
      .hit      (hit[i]),
      .dist_all (dist_cm),
      .hit_all  (hit),
      .rank     (rank[i]),
      .dist_q   (dist_q[i]),
      .hit_q    (hit_q[i])
    );
  end

  umlp_merge u_merge (
    .clk               (clk),
    .dist_cm           (dist_q),
    .hit               (hit_q),
    .rank              (rank),
    .full_distance_cm  (full_distance_cm),
    .empty_distance_cm (empty_distance_cm),
    .num               (num),
    .den               (den),
    .meta              (meta_m)
  );

  umlp_div u_div (
    .clk      (clk),
    .num      (num),
    .den      (den),
    .meta_in  (meta_m),
    .quo      (quo),
    .meta_out (meta_d)
  );

  always_comb begin
    if (quo <= BAND_LOW_MAX) begin
      band_next = BAND_LOW;
    end else if (quo <= BAND_MID_MAX) begin
      band_next = BAND_MID;
    end else begin
      band_next = BAND_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    level_percent <= quo;
    median_cm     <= meta_d.median;
    level_band    <= band_next;
    sensor_error  <= meta_d.err;
    valid_count   <= meta_d.count;
  end

  assign done = vld[LATENCY-1];

endmodule

[rtl/umlp_chk.sv]
// Port-level checker for the ultrasonic median level block, bound to the top.
// Depends on umlp_pkg and ultrasonic_median_level_percent.
module umlp_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [umlp_pkg::PCT_W-1:0]     level_percent,
  input logic [umlp_pkg::CFG_W-1:0]     median_cm,
  input logic [1:0]                     level_band,
  input logic                           sensor_error,
  input logic [umlp_pkg::CNT_W-1:0]     valid_count
);
  import umlp_pkg::*;

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && sensor_error |-> level_percent == '0 && level_band == BAND_LOW)
    else $error("error result carries a level");

  a_no_echo: assert property (@(posedge clk) disable iff (rst)
    done && valid_count == '0 |-> sensor_error && median_cm == '0)
    else $error("empty window not flagged");

  a_band: assert property (@(posedge clk) disable iff (rst)
    done |-> level_percent <= PCT_SCALE &&
             ((level_band == BAND_LOW) == (level_percent <= BAND_LOW_MAX)) &&
             ((level_band == BAND_HIGH) == (level_percent > BAND_MID_MAX)))
    else $error("band does not match percent");

endmodule

bind ultrasonic_median_level_percent umlp_chk u_umlp_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .level_percent (level_percent),
  .median_cm     (median_cm),
  .level_band    (level_band),
  .sensor_error  (sensor_error),
  .valid_count   (valid_count)
);

[tb/ultrasonic_median_level_percent_tb.sv]
// Self-checking testbench for ultrasonic_median_level_percent: directed table, then random phases.
// Every request's result is predicted here or typed into the table, and compared with the result on done.
// Depends on rtl/umlp_pkg.sv and the block itself; needs nothing else.
module ultrasonic_median_level_percent_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import umlp_pkg::*;

  localparam int PHASES         = 12;
  localparam int REQS_PER_PHASE = 125;
  localparam int MAX_DIST       = 278;

  typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [CFG_W-1:0] median;
    band_t            band;
    logic             err;
    logic [CNT_W-1:0] count;
  } level_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    echo_vec_t            echo;
    logic                 typed;
    level_t               lvl;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic [ECHO_W-1:0]    echo_us_0, echo_us_1, echo_us_2, echo_us_3, echo_us_4;
  logic                 done;
  logic [PCT_W-1:0]     level_percent;
  logic [CFG_W-1:0]     median_cm;
  logic [1:0]           level_band;
  logic                 sensor_error;
  logic [CNT_W-1:0]     valid_count;

  level_t           level_q[$];
  logic [CFG_W-1:0] full_cm;
  logic [CFG_W-1:0] empty_cm;
  int               mismatches = 0;

  ultrasonic_median_level_percent dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .echo_us_0(echo_us_0), .echo_us_1(echo_us_1), .echo_us_2(echo_us_2),
    .echo_us_3(echo_us_3), .echo_us_4(echo_us_4),
    .done(done), .level_percent(level_percent), .median_cm(median_cm),
    .level_band(level_band), .sensor_error(sensor_error), .valid_count(valid_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic level_t predict_level(echo_vec_t e, logic [CFG_W-1:0] full_r,
                                           logic [CFG_W-1:0] empty_r);
    int unsigned dist_cm[SAMPLE_COUNT];
    int unsigned n, d, key, j, med, pct, full, empty;
    level_t r;
    r = '0;
    n = 0;
    full = 32'(full_r);
    empty = 32'(empty_r);
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      d = (32'(e[i]) * 17) / 1000;
      if (d > 0) begin
        dist_cm[n] = d;
        n++;
      end
    end
    r.count = n[CNT_W-1:0];
    if (n == 0) begin
      r.err = 1'b1;
      return r;
    end
    for (int i = 1; i < n; i++) begin
      key = dist_cm[i];
      j = i;
      while (j > 0 && dist_cm[j-1] > key) begin
        dist_cm[j] = dist_cm[j-1];
        j--;
      end
      dist_cm[j] = key;
    end
    med = dist_cm[n/2];      // upper median when n is even
    if (med < full) med = full;
    else if (med > empty) med = empty;
    r.median = med[CFG_W-1:0];
    if (empty <= full) begin
      r.err = 1'b1;
    end else begin
      pct = ((empty - med) * 100) / (empty - full);
      if (pct > 100) pct = 100;
      r.pct = pct[PCT_W-1:0];
      if (pct <= 30) r.band = BAND_LOW;
      else if (pct <= 70) r.band = BAND_MID;
      else r.band = BAND_HIGH;
    end
    return r;
  endfunction

  function automatic stim_row_t wr_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t req_row(echo_vec_t e);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.echo = e;
    return r;
  endfunction

  function automatic stim_row_t chk_row(echo_vec_t e, int pct, int med, band_t band,
                                        logic err, int cnt);
    stim_row_t r;
    r = req_row(e);
    r.typed = 1'b1;
    r.lvl.pct = pct[PCT_W-1:0];
    r.lvl.median = med[CFG_W-1:0];
    r.lvl.band = band;
    r.lvl.err = err;
    r.lvl.count = cnt[CNT_W-1:0];
    return r;
  endfunction

  // Widths aimed at the configured range, timeouts, 0..2 cm widths, raw noise; unshaped: timeouts, noise.
  function automatic echo_vec_t rand_window(bit shaped);
    echo_vec_t e;
    int unsigned lo, hi, d, w, pick;
    lo = (full_cm > 5) ? full_cm - 5 : 0;
    hi = (empty_cm + 5 > MAX_DIST) ? MAX_DIST : empty_cm + 5;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      pick = $urandom_range(0, 99);
      if (!shaped) pick = (pick < 30) ? 70 : 95;
      if (pick < 60) begin
        d = $urandom_range(lo, hi);
        w = (d * 1000 + 16) / 17 + $urandom_range(0, 58);
        if (w > 16383) w = 16383;
      end else if (pick < 75) begin
        w = 0;
      end else if (pick < 85) begin
        w = $urandom_range(0, 120);
      end else begin
        w = $urandom_range(0, 16383);
      end
      e[i] = w[ECHO_W-1:0];
    end
    return e;
  endfunction

  task automatic send_window(echo_vec_t e, logic typed, level_t typed_lvl);
    start = 1'b1;
    echo_us_0 = e[0];
    echo_us_1 = e[1];
    echo_us_2 = e[2];
    echo_us_3 = e[3];
    echo_us_4 = e[4];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) level_q.push_back(typed_lvl);
    else level_q.push_back(predict_level(e, full_cm, empty_cm));
    @(negedge clk);
  endtask

  task automatic idle_gap(bit no_gaps);
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (level_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FULL) full_cm = data;
    else empty_cm = data;
  endtask

  task automatic set_range(int unsigned full, int unsigned empty);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FULL, full[CFG_W-1:0]);
      write_reg(REG_EMPTY, empty[CFG_W-1:0]);
    end else begin
      write_reg(REG_EMPTY, empty[CFG_W-1:0]);
      write_reg(REG_FULL, full[CFG_W-1:0]);
    end
  endtask

  always @(posedge clk) begin
    level_t want;
    if (!rst && done) begin
      if (level_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: pct %0d median %0d", $time,
                 level_percent, median_cm);
      end else begin
        want = level_q.pop_front();
        if (level_percent !== want.pct) begin
          mismatches++;
          $display("%0t: level_percent expected %0d got %0d", $time, want.pct, level_percent);
        end
        if (median_cm !== want.median) begin
          mismatches++;
          $display("%0t: median_cm expected %0d got %0d", $time, want.median, median_cm);
        end
        if (level_band !== want.band) begin
          mismatches++;
          $display("%0t: level_band expected %0d got %0d", $time, want.band, level_band);
        end
        if (sensor_error !== want.err) begin
          mismatches++;
          $display("%0t: sensor_error expected %0d got %0d", $time, want.err, sensor_error);
        end
        if (valid_count !== want.count) begin
          mismatches++;
          $display("%0t: valid_count expected %0d got %0d", $time, want.count, valid_count);
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int unsigned full, empty, r;
    bit no_gaps;

    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FULL;
    cfg_data = '0;
    {echo_us_0, echo_us_1, echo_us_2, echo_us_3, echo_us_4} = '0;
    full_cm = FULL_RESET;
    empty_cm = EMPTY_RESET;

    // reset range 25..130 cm; 59 us is the first width giving 1 cm
    rows.push_back(chk_row({5{14'd0}}, 0, 0, BAND_LOW, 1'b1, 0));
    rows.push_back(chk_row({5{14'd58}}, 0, 0, BAND_LOW, 1'b1, 0));
    rows.push_back(chk_row({5{14'd59}}, 100, 25, BAND_HIGH, 1'b0, 5));
    rows.push_back(chk_row({5{14'd16383}}, 0, 130, BAND_LOW, 1'b0, 5));
    rows.push_back(chk_row({14'd16383, 14'd0, 14'd59, 14'd0, 14'd0}, 0, 130, BAND_LOW, 1'b0, 2));
    rows.push_back(req_row({14'd2353, 14'd3530, 14'd0, 14'd4706, 14'd5883}));
    rows.push_back(req_row({14'd5883, 14'd2353, 14'd4706, 14'd3530, 14'd7059}));
    rows.push_back(req_row({5{14'd1471}}));
    rows.push_back(req_row({5{14'd7648}}));
    // band edges: 98 cm -> 30%, 97 cm -> 31%, 56 cm -> 70%, 55 cm -> 71%
    rows.push_back(req_row({14'd0, 14'd0, 14'd5765, 14'd0, 14'd0}));
    rows.push_back(req_row({14'd5706, 14'd0, 14'd0, 14'd0, 14'd0}));
    rows.push_back(req_row({14'd0, 14'd0, 14'd0, 14'd3295, 14'd0}));
    rows.push_back(req_row({14'd0, 14'd3236, 14'd0, 14'd0, 14'd0}));
    // empty == full: error, median still clamped
    rows.push_back(wr_row(REG_FULL, 8'd100));
    rows.push_back(wr_row(REG_EMPTY, 8'd100));
    rows.push_back(chk_row({5{14'd5883}}, 0, 100, BAND_LOW, 1'b1, 5));
    rows.push_back(chk_row({5{14'd2353}}, 0, 100, BAND_LOW, 1'b1, 5));
    // empty below full
    rows.push_back(wr_row(REG_FULL, 8'd200));
    rows.push_back(wr_row(REG_EMPTY, 8'd50));
    rows.push_back(req_row({5{14'd7059}}));
    rows.push_back(req_row({5{14'd16383}}));
    rows.push_back(req_row({14'd0, 14'd0, 14'd0, 14'd0, 14'd0}));
    rows.push_back(wr_row(REG_FULL, 8'd0));
    rows.push_back(wr_row(REG_EMPTY, 8'd255));
    rows.push_back(chk_row({5{14'd16383}}, 0, 255, BAND_LOW, 1'b0, 5));
    rows.push_back(req_row({5{14'd59}}));
    rows.push_back(wr_row(REG_FULL, 8'd254));
    rows.push_back(req_row({5{14'd59}}));
    rows.push_back(req_row({14'd16383, 14'd59, 14'd12345, 14'd0, 14'd8191}));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_window(rows[i].echo, rows[i].typed, rows[i].lvl);
        idle_gap(1'b0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin full = 0;   empty = 255; end
        1: begin full = 255; empty = 0;   end
        2: begin full = 0;   empty = 0;   end
        3: begin full = 255; empty = 255; end
        4: begin full = 25;  empty = 130; end
        default: begin
          r = $urandom_range(0, 3);
          full = $urandom_range(0, 200);
          empty = (r == 0) ? $urandom_range(0, 255) : $urandom_range(full + 1, 255);
        end
      endcase
      set_range(full, empty);
      no_gaps = (p % 4 == 1);
      for (int k = 0; k < REQS_PER_PHASE; k++) begin
        send_window(rand_window($urandom_range(0, 99) < 80), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) drain();
        idle_gap(no_gaps);
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/umlp_pkg.sv
rtl/umlp_lane.sv
rtl/umlp_merge.sv
rtl/umlp_div.sv
rtl/ultrasonic_median_level_percent.sv
rtl/umlp_chk.sv
tb/ultrasonic_median_level_percent_tb.sv
